// File: rtl/tgts_pkg.sv
// Shared types and constants of the two-group task slot scheduler.
package tgts_pkg;

   localparam int unsigned DEF_SLOT_COUNT = 16;

   localparam int unsigned REQ_TYPE_W    = 3;
   localparam int unsigned SLOT_ID_W     = 4;
   localparam int unsigned RESULT_SLOT_W = 4;
   localparam int unsigned SEL_W         = 16;
   localparam int unsigned DESC_W        = 13;
   localparam int unsigned RANK_W        = 3;
   localparam int unsigned CSR_INDEX_W   = 1;
   localparam int unsigned CSR_DATA_W    = 16;

   localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_DESC = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_SEL   = 1'd1;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_SCHEDULE    = 3'd0,
      REQ_CREATE      = 3'd1,
      REQ_REMOVE_ID   = 3'd2,
      REQ_REMOVE_CUR  = 3'd3,
      REQ_FIND_OLDEST = 3'd4
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TGT_RD,
      ST_TGT_EV,
      ST_RD,
      ST_EV,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic              rank_we;
      logic              alloc_we;
      logic              alloc_val;
      logic [RANK_W-1:0] rank;
   } tbl_wr_type;

   typedef struct packed {
      logic                     ok;
      logic [RESULT_SLOT_W-1:0] slot;
      logic [SEL_W-1:0]         selector;
      logic [RANK_W-1:0]        age_rank;
   } rsp_type;

endpackage

// File: rtl/tgts_slot_table.sv
// Slot table: allocated bits in flip-flops, age ranks in a one-port memory.
module tgts_slot_table #(
   parameter int unsigned SLOT_COUNT = tgts_pkg::DEF_SLOT_COUNT,
   localparam int unsigned IdW = $clog2(SLOT_COUNT)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [IdW-1:0]             addr,
   input  tgts_pkg::tbl_wr_type       wr,
   output logic                       rd_alloc,
   output logic [tgts_pkg::RANK_W-1:0] rd_rank
);
   import tgts_pkg::*;

   logic [SLOT_COUNT-1:0] alloc_ff;
   logic [SLOT_COUNT-1:0] alloc_in;
   logic [RANK_W-1:0]     rank_ff [SLOT_COUNT];
   logic                  rd_alloc_ff;
   logic [RANK_W-1:0]     rd_rank_ff;

   always_comb begin
      alloc_in = alloc_ff;
      if (wr.alloc_we) begin
         alloc_in[addr] = wr.alloc_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff <= '0;
      end else begin
         alloc_ff <= alloc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.rank_we) begin
         rank_ff[addr] <= wr.rank;
      end
      rd_rank_ff  <= rank_ff[addr];
      rd_alloc_ff <= alloc_ff[addr];
   end

   // a free slot reads as rank zero
   assign rd_alloc = rd_alloc_ff;
   assign rd_rank  = rd_alloc_ff ? rd_rank_ff : '0;

endmodule

// File: rtl/tgts_sequencer.sv
// Sequencer: walks one group's slots through the table, a read state then an evaluate state for each slot.
module tgts_sequencer #(
   parameter int unsigned SLOT_COUNT = tgts_pkg::DEF_SLOT_COUNT,
   localparam int unsigned IdW = $clog2(SLOT_COUNT)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_fire,
   input  logic [tgts_pkg::REQ_TYPE_W-1:0]   req_type,
   input  logic                              req_group,
   input  logic [tgts_pkg::SLOT_ID_W-1:0]    req_slot_id,
   input  logic                              req_spawn_ok,
   input  logic                              req_hold,
   output logic                              busy,
   input  logic [tgts_pkg::DESC_W-1:0]       first_desc,
   input  logic [tgts_pkg::SEL_W-1:0]        idle_sel,
   input  logic                              out_free,
   output logic                              done,
   output tgts_pkg::rsp_type                 rsp,
   output logic [IdW-1:0]                    tbl_addr,
   output tgts_pkg::tbl_wr_type              tbl_wr,
   input  logic                              tbl_alloc,
   input  logic [tgts_pkg::RANK_W-1:0]       tbl_rank
);
   import tgts_pkg::*;

   localparam int unsigned SchedSteps = SLOT_COUNT / 2;
   localparam int unsigned GrpSteps   = (SLOT_COUNT + 1) / 2;
   localparam int unsigned RmSteps    = GrpSteps - 1;
   localparam int unsigned StW        = $clog2(GrpSteps + 1);
   localparam int unsigned CmpW       = ((IdW > SLOT_ID_W) ? IdW : SLOT_ID_W) + 1;

   seq_state_type     state_ff, state_in;
   req_kind_type      op_ff, op_in;
   logic              spawn_ff, spawn_in;
   logic              hold_ff, hold_in;
   logic              served_ff, served_in;
   logic [IdW-1:0]    pos_ff, pos_in;
   logic [StW-1:0]    steps_ff, steps_in;
   logic              hit_ff, hit_in;
   logic [IdW-1:0]    hit_slot_ff, hit_slot_in;
   logic [RANK_W-1:0] top_ff, top_in;
   logic              any_ff, any_in;
   logic [RANK_W-1:0] removed_ff, removed_in;
   logic [IdW-1:0]    target_ff, target_in;
   logic              tgt_ok_ff, tgt_ok_in;
   logic [IdW-1:0]    lpa_ff, lpa_in;
   logic [IdW-1:0]    lpb_ff, lpb_in;
   logic              lgr_ff, lgr_in;

   logic [RANK_W-1:0] new_rank;
   logic [DESC_W-1:0] desc_sum;

   function automatic logic [IdW-1:0] next_pos(input logic [IdW-1:0] cur);
      logic [IdW:0] sum;
      sum = {1'b0, cur} + (IdW+1)'(2);
      if (sum >= (IdW+1)'(SLOT_COUNT)) begin
         sum = sum - (IdW+1)'(SLOT_COUNT);
      end
      return sum[IdW-1:0];
   endfunction

   function automatic logic [RESULT_SLOT_W-1:0] out_slot(input logic [IdW-1:0] cur);
      logic [CmpW-1:0] wide;
      wide = CmpW'(cur);
      return wide[RESULT_SLOT_W-1:0];
   endfunction

   assign new_rank = !any_ff ? '0 : (top_ff == RANK_MAX) ? RANK_MAX : top_ff + 3'd1;
   assign desc_sum = first_desc + DESC_W'(hit_slot_ff);
   assign busy     = (state_ff != ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      spawn_in    = spawn_ff;
      hold_in     = hold_ff;
      served_in   = served_ff;
      pos_in      = pos_ff;
      steps_in    = steps_ff;
      hit_in      = hit_ff;
      hit_slot_in = hit_slot_ff;
      top_in      = top_ff;
      any_in      = any_ff;
      removed_in  = removed_ff;
      target_in   = target_ff;
      tgt_ok_in   = tgt_ok_ff;
      lpa_in      = lpa_ff;
      lpb_in      = lpb_ff;
      lgr_in      = lgr_ff;
      done        = 1'b0;
      rsp         = '0;
      tbl_addr    = pos_ff;
      tbl_wr      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in     = req_kind_type'(req_type);
               spawn_in  = req_spawn_ok;
               hold_in   = req_hold;
               served_in = ~lgr_ff;
               hit_in    = 1'b0;
               any_in    = 1'b0;
               top_in    = '0;
               case (req_kind_type'(req_type))
                  REQ_SCHEDULE: begin
                     pos_in   = next_pos(lgr_ff ? lpa_ff : lpb_ff);
                     steps_in = StW'(SchedSteps);
                     state_in = req_hold ? ST_DONE : ST_RD;
                  end
                  REQ_CREATE, REQ_FIND_OLDEST: begin
                     pos_in   = IdW'(req_group);
                     steps_in = StW'(GrpSteps);
                     state_in = ST_RD;
                  end
                  REQ_REMOVE_ID: begin
                     target_in = IdW'(req_slot_id);
                     tgt_ok_in = (CmpW'(req_slot_id) < CmpW'(SLOT_COUNT));
                     state_in  = ST_TGT_RD;
                  end
                  REQ_REMOVE_CUR: begin
                     target_in = lgr_ff ? lpb_ff : lpa_ff;
                     tgt_ok_in = 1'b1;
                     state_in  = ST_TGT_RD;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_TGT_RD: begin
            tbl_addr = target_ff;
            state_in = ST_TGT_EV;
         end

         ST_TGT_EV: begin
            tbl_addr = target_ff;
            if (tgt_ok_ff && tbl_alloc) begin
               hit_in     = 1'b1;
               removed_in = tbl_rank;
               pos_in     = next_pos(target_ff);
               steps_in   = StW'(RmSteps);
               state_in   = (RmSteps == 0) ? ST_DONE : ST_RD;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_RD: begin
            state_in = ST_EV;
         end

         ST_EV: begin
            case (op_ff)
               REQ_SCHEDULE: begin
                  if (!hit_ff && tbl_alloc) begin
                     hit_in      = 1'b1;
                     hit_slot_in = pos_ff;
                  end
               end
               REQ_CREATE: begin
                  if (!hit_ff && !tbl_alloc) begin
                     hit_in      = 1'b1;
                     hit_slot_in = pos_ff;
                  end
                  if (tbl_alloc) begin
                     any_in = 1'b1;
                     if (tbl_rank > top_ff) begin
                        top_in = tbl_rank;
                     end
                  end
               end
               REQ_FIND_OLDEST: begin
                  if (!hit_ff && tbl_alloc && tbl_rank == '0) begin
                     hit_in      = 1'b1;
                     hit_slot_in = pos_ff;
                  end
               end
               REQ_REMOVE_ID, REQ_REMOVE_CUR: begin
                  // lower every younger task of the group
                  if (tbl_alloc && tbl_rank > removed_ff) begin
                     tbl_wr.rank_we = 1'b1;
                     tbl_wr.rank    = tbl_rank - 3'd1;
                  end
               end
               default: begin
               end
            endcase
            steps_in = steps_ff - StW'(1);
            pos_in   = next_pos(pos_ff);
            state_in = (steps_ff == StW'(1)) ? ST_DONE : ST_RD;
         end

         ST_DONE: begin
            tbl_addr = (op_ff == REQ_CREATE) ? hit_slot_ff : target_ff;
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
               case (op_ff)
                  REQ_SCHEDULE: begin
                     rsp.selector = idle_sel;
                     if (!hold_ff) begin
                        lgr_in = served_ff;
                        if (hit_ff) begin
                           if (served_ff) begin
                              lpb_in = hit_slot_ff;
                           end else begin
                              lpa_in = hit_slot_ff;
                           end
                           rsp.ok       = 1'b1;
                           rsp.slot     = out_slot(hit_slot_ff);
                           rsp.selector = {desc_sum, 3'b000};
                        end
                     end
                  end
                  REQ_CREATE: begin
                     if (hit_ff && spawn_ff) begin
                        tbl_wr.rank_we   = 1'b1;
                        tbl_wr.rank      = new_rank;
                        tbl_wr.alloc_we  = 1'b1;
                        tbl_wr.alloc_val = 1'b1;
                        rsp.ok           = 1'b1;
                        rsp.slot         = out_slot(hit_slot_ff);
                        rsp.age_rank     = new_rank;
                     end
                  end
                  REQ_REMOVE_ID, REQ_REMOVE_CUR: begin
                     if (hit_ff) begin
                        tbl_wr.alloc_we  = 1'b1;
                        tbl_wr.alloc_val = 1'b0;
                        rsp.ok           = 1'b1;
                        rsp.slot         = out_slot(target_ff);
                     end
                  end
                  REQ_FIND_OLDEST: begin
                     if (hit_ff) begin
                        rsp.ok   = 1'b1;
                        rsp.slot = out_slot(hit_slot_ff);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lpa_ff   <= '0;
         lpb_ff   <= IdW'(1);
         lgr_ff   <= 1'b1;
      end else begin
         state_ff <= state_in;
         lpa_ff   <= lpa_in;
         lpb_ff   <= lpb_in;
         lgr_ff   <= lgr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      spawn_ff    <= spawn_in;
      hold_ff     <= hold_in;
      served_ff   <= served_in;
      pos_ff      <= pos_in;
      steps_ff    <= steps_in;
      hit_ff      <= hit_in;
      hit_slot_ff <= hit_slot_in;
      top_ff      <= top_in;
      any_ff      <= any_in;
      removed_ff  <= removed_in;
      target_ff   <= target_in;
      tgt_ok_ff   <= tgt_ok_in;
   end

endmodule

// File: rtl/two_group_task_slot_scheduler_unit.sv
// A schedule on hold or an unknown request type goes straight to the done state and walks
// no slots. One request is in progress at a time: the sequencer reads the slots through
// the table's registered read port, and req_stall stays high from accept until the
// result is loaded for output, which waits while an earlier result is held by rsp_stall.
// Synchronous reset clears the allocated bits, the last picks (A to 0, B to 1), the last
// group run (B), the output valid and both registers.
module two_group_task_slot_scheduler_unit #(
   parameter int unsigned SLOT_COUNT = tgts_pkg::DEF_SLOT_COUNT,
   localparam int unsigned IdW = $clog2(SLOT_COUNT)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [tgts_pkg::REQ_TYPE_W-1:0]     req_type,
   input  logic                                req_group,
   input  logic [tgts_pkg::SLOT_ID_W-1:0]      req_slot_id,
   input  logic                                req_spawn_ok,
   input  logic                                req_hold,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_ok,
   output logic [tgts_pkg::RESULT_SLOT_W-1:0]  rsp_result_slot,
   output logic [tgts_pkg::SEL_W-1:0]          rsp_selector,
   output logic [tgts_pkg::RANK_W-1:0]         rsp_age_rank,
   input  logic                                csr_we,
   input  logic [tgts_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tgts_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tgts_pkg::*;

   logic [DESC_W-1:0] first_desc_ff, first_desc_in;
   logic [SEL_W-1:0]  idle_sel_ff, idle_sel_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              req_fire;
   logic              busy;
   logic              out_free;
   logic              seq_done;
   rsp_type           seq_rsp;
   logic [IdW-1:0]    tbl_addr;
   tbl_wr_type        tbl_wr;
   logic              tbl_alloc;
   logic [RANK_W-1:0] tbl_rank;

   assign req_stall = busy;
   assign req_fire  = req_valid && !busy;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      first_desc_in = first_desc_ff;
      idle_sel_in   = idle_sel_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FIRST_DESC: first_desc_in = csr_wdata[DESC_W-1:0];
            CSR_IDLE_SEL:   idle_sel_in   = csr_wdata[SEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_desc_ff <= '0;
         idle_sel_ff   <= '0;
      end else begin
         first_desc_ff <= first_desc_in;
         idle_sel_ff   <= idle_sel_in;
      end
   end

   tgts_slot_table #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .addr     (tbl_addr),
      .wr       (tbl_wr),
      .rd_alloc (tbl_alloc),
      .rd_rank  (tbl_rank)
   );

   tgts_sequencer #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_fire     (req_fire),
      .req_type     (req_type),
      .req_group    (req_group),
      .req_slot_id  (req_slot_id),
      .req_spawn_ok (req_spawn_ok),
      .req_hold     (req_hold),
      .busy         (busy),
      .first_desc   (first_desc_ff),
      .idle_sel     (idle_sel_ff),
      .out_free     (out_free),
      .done         (seq_done),
      .rsp          (seq_rsp),
      .tbl_addr     (tbl_addr),
      .tbl_wr       (tbl_wr),
      .tbl_alloc    (tbl_alloc),
      .tbl_rank     (tbl_rank)
   );

   // hold the result until taken; load a new one only into a free register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (seq_done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = seq_rsp;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ff.ok;
   assign rsp_result_slot = rsp_ff.slot;
   assign rsp_selector    = rsp_ff.selector;
   assign rsp_age_rank    = rsp_ff.age_rank;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> req_stall)
      else $error("sequencer took a second item while working");

   a_done_into_free_reg: assert property (@(posedge clock) disable iff (reset)
      seq_done |-> out_free)
      else $error("result overwrote one still waiting");

   a_fail_clears_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_result_slot == '0 && rsp_age_rank == '0)
      else $error("failed request returned a slot or rank");

   a_no_done_while_idle: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !seq_done)
      else $error("result produced with no item in progress");

endmodule

// File: sim/tb_two_group_task_slot_scheduler_unit.sv
// Self-checking testbench of the two-group task slot scheduler unit.
`timescale 1ns / 100ps

module tb_two_group_task_slot_scheduler_unit;
   import tgts_pkg::*;

   localparam int SLOTS          = DEF_SLOT_COUNT;
   localparam int RESET_CYCLES   = 10;
   localparam int DRAIN_CYCLES   = 2 * SLOTS + 8;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int STALL_LIMIT    = 4000;
   localparam int PHASE_ITEMS    = 245;
   localparam int MAX_REPORTS    = 100;

   // Scoreboard: carries its own copy of the slot table, predicts each result.
   class slot_table_scoreboard;
      bit                allocated [SLOTS];
      bit [RANK_W-1:0]   age [SLOTS];
      bit [3:0]          pick_a;
      bit [3:0]          pick_b;
      bit                ran_group_b;
      bit [DESC_W-1:0]   first_desc;
      bit [SEL_W-1:0]    idle_sel;
      rsp_type           expected_q [$];
      int                errors;

      function new();
         int i;
         for (i = 0; i < SLOTS; i++) begin
            allocated[i] = 1'b0;
            age[i] = '0;
         end
         pick_a = 4'd0;
         pick_b = 4'd1;
         ran_group_b = 1'b1;
         first_desc = '0;
         idle_sel = '0;
         errors = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_FIRST_DESC) first_desc = data[DESC_W-1:0];
         else idle_sel = data[SEL_W-1:0];
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Lower the younger tasks of the same group, then free the slot.
      function bit vacate_slot(int target);
         int i;
         int s;
         bit [RANK_W-1:0] gone;
         if (!allocated[target]) return 1'b0;
         gone = age[target];
         for (i = target + 2; i < target + SLOTS; i += 2) begin
            s = i % SLOTS;
            if (allocated[s] && age[s] > gone) age[s] = age[s] - 1'b1;
         end
         allocated[target] = 1'b0;
         return 1'b1;
      endfunction

      function void note_request(logic [REQ_TYPE_W-1:0] kind, logic grp,
                                 logic [SLOT_ID_W-1:0] sid, logic spawn, logic hold);
         rsp_type r;
         int i;
         int s;
         int last;
         int top;
         int target;
         bit served;
         bit found;
         bit any;
         logic [DESC_W-1:0] desc;
         r = '0;
         case (kind)
            REQ_SCHEDULE: begin
               r.selector = idle_sel;
               if (!hold) begin
                  served = ~ran_group_b;
                  last = served ? pick_b : pick_a;
                  for (i = last + 2; i <= last + SLOTS; i += 2) begin
                     s = i % SLOTS;
                     if (allocated[s]) begin
                        if (served) pick_b = 4'(s);
                        else pick_a = 4'(s);
                        desc = first_desc + DESC_W'(s);
                        r.ok = 1'b1;
                        r.slot = 4'(s);
                        r.selector = {desc, 3'b000};
                        break;
                     end
                  end
                  ran_group_b = served;
               end
            end
            REQ_CREATE: begin
               found = 1'b0;
               s = 0;
               for (i = grp; i < grp + SLOTS; i += 2) begin
                  if (!allocated[i % SLOTS]) begin
                     s = i % SLOTS;
                     found = 1'b1;
                     break;
                  end
               end
               if (found && spawn) begin
                  any = 1'b0;
                  top = 0;
                  for (i = grp; i < grp + SLOTS; i += 2) begin
                     if (allocated[i % SLOTS] && top <= age[i % SLOTS]) begin
                        top = age[i % SLOTS];
                        any = 1'b1;
                     end
                  end
                  top = any ? top + 1 : 0;
                  if (top > RANK_MAX) top = RANK_MAX;
                  allocated[s] = 1'b1;
                  age[s] = RANK_W'(top);
                  r.ok = 1'b1;
                  r.slot = 4'(s);
                  r.age_rank = RANK_W'(top);
               end
            end
            REQ_REMOVE_ID, REQ_REMOVE_CUR: begin
               if (kind == REQ_REMOVE_ID) target = sid;
               else target = ran_group_b ? pick_b : pick_a;
               if (vacate_slot(target)) begin
                  r.ok = 1'b1;
                  r.slot = 4'(target);
               end
            end
            REQ_FIND_OLDEST: begin
               for (i = grp; i < grp + SLOTS; i += 2) begin
                  s = i % SLOTS;
                  if (allocated[s] && age[s] == 0) begin
                     r.ok = 1'b1;
                     r.slot = 4'(s);
                     break;
                  end
               end
            end
            default: ;
         endcase
         expected_q.push_back(r);
      endfunction

      function void mismatch(string field, int exp_val, int act_val);
         if (errors < MAX_REPORTS)
            $error("%s: expected %0d, got %0d", field, exp_val, act_val);
         errors++;
      endfunction

      function void check_result(logic ok, logic [RESULT_SLOT_W-1:0] slot,
                                 logic [SEL_W-1:0] sel, logic [RANK_W-1:0] rank);
         rsp_type e;
         if (expected_q.size() == 0) begin
            if (errors < MAX_REPORTS)
               $error("result with nothing outstanding: ok=%0d slot=%0d selector=%0d",
                      ok, slot, sel);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (ok !== e.ok) mismatch("ok", e.ok, ok);
         if (slot !== e.slot) mismatch("result_slot", e.slot, slot);
         if (sel !== e.selector) mismatch("selector", e.selector, sel);
         if (rank !== e.age_rank) mismatch("age_rank", e.age_rank, rank);
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [REQ_TYPE_W-1:0]    req_type;
   logic                     req_group;
   logic [SLOT_ID_W-1:0]     req_slot_id;
   logic                     req_spawn_ok;
   logic                     req_hold;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_ok;
   logic [RESULT_SLOT_W-1:0] rsp_result_slot;
   logic [SEL_W-1:0]         rsp_selector;
   logic [RANK_W-1:0]        rsp_age_rank;
   logic                     csr_we;
   logic [CSR_INDEX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]    csr_wdata;

   slot_table_scoreboard sb;
   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   bit  holdoff_armed  = 1'b0;
   bit  holdoff_done   = 1'b0;
   int  idle_cycles    = 0;
   bit  req_fire;
   bit  rsp_fire;
   int  k;

   two_group_task_slot_scheduler_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_group       (req_group),
      .req_slot_id     (req_slot_id),
      .req_spawn_ok    (req_spawn_ok),
      .req_hold        (req_hold),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_ok          (rsp_ok),
      .rsp_result_slot (rsp_result_slot),
      .rsp_selector    (rsp_selector),
      .rsp_age_rank    (rsp_age_rank),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_item(input logic [REQ_TYPE_W-1:0] kind, input logic grp,
                            input logic [SLOT_ID_W-1:0] sid, input logic spawn,
                            input logic hold);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_group    <= grp;
      req_slot_id  <= sid;
      req_spawn_ok <= spawn;
      req_hold     <= hold;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic random_item();
      int r;
      logic [REQ_TYPE_W-1:0] kind;
      r = $urandom_range(99);
      if (r < 35) kind = REQ_SCHEDULE;
      else if (r < 60) kind = REQ_CREATE;
      else if (r < 75) kind = REQ_REMOVE_ID;
      else if (r < 85) kind = REQ_REMOVE_CUR;
      else if (r < 95) kind = REQ_FIND_OLDEST;
      else kind = REQ_TYPE_W'($urandom_range(2**REQ_TYPE_W - 1, int'(REQ_FIND_OLDEST) + 1));
      send_item(kind, 1'($urandom_range(1)), SLOT_ID_W'($urandom_range(2**SLOT_ID_W - 1)),
                $urandom_range(9) != 0, $urandom_range(99) < 15);
   endtask

   // Drop valid, wait for every outstanding result, then let the block settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Both registers back to back; write enable stays high across the pair.
   task automatic write_config(input logic [CSR_DATA_W-1:0] first_desc,
                               input logic [CSR_DATA_W-1:0] idle_sel);
      csr_we    <= 1'b1;
      csr_index <= CSR_FIRST_DESC;
      csr_wdata <= first_desc;
      sb.write_register(CSR_FIRST_DESC, first_desc);
      @(posedge clock);
      csr_index <= CSR_IDLE_SEL;
      csr_wdata <= idle_sel;
      sb.write_register(CSR_IDLE_SEL, idle_sel);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct,
                            input logic [CSR_DATA_W-1:0] first_desc,
                            input logic [CSR_DATA_W-1:0] idle_sel, input bit holdoff);
      wait_drained();
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      write_config(first_desc, idle_sel);
      if (holdoff) holdoff_armed = 1'b1;
      repeat (PHASE_ITEMS) random_item();
   endtask

   // Receiver: random stall, plus one long hold-off while the sender keeps offering.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_armed && !holdoff_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
            holdoff_done = 1'b1;
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         rsp_fire = (rsp_valid === 1'b1) && (rsp_stall === 1'b0);
         req_fire = (req_valid === 1'b1) && (req_stall === 1'b0);
         if (rsp_fire) sb.check_result(rsp_ok, rsp_result_slot, rsp_selector, rsp_age_rank);
         if (req_fire)
            sb.note_request(req_type, req_group, req_slot_id, req_spawn_ok, req_hold);
         if (rsp_fire || req_fire) idle_cycles = 0;
         else idle_cycles++;
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      sb = new();
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_type     <= REQ_SCHEDULE;
      req_group    <= 1'b0;
      req_slot_id  <= '0;
      req_spawn_ok <= 1'b0;
      req_hold     <= 1'b0;
      csr_we       <= 1'b0;
      csr_index    <= CSR_FIRST_DESC;
      csr_wdata    <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed items on the reset register values.
      send_item(REQ_SCHEDULE, 1'b0, 4'd0, 1'b1, 1'b0);     // empty table, idle selector
      send_item(REQ_SCHEDULE, 1'b1, 4'd0, 1'b1, 1'b1);     // hold
      send_item(REQ_REMOVE_CUR, 1'b0, 4'd0, 1'b1, 1'b0);   // nothing current
      send_item(REQ_FIND_OLDEST, 1'b0, 4'd0, 1'b1, 1'b0);  // empty group
      send_item(REQ_CREATE, 1'b0, 4'd0, 1'b0, 1'b0);       // spawn check rejects
      // fill group A, then one more create finds no free slot
      repeat (SLOTS / 2 + 1) send_item(REQ_CREATE, 1'b0, 4'd0, 1'b1, 1'b0);
      send_item(REQ_CREATE, 1'b1, 4'hF, 1'b1, 1'b1);
      send_item(REQ_CREATE, 1'b1, 4'd0, 1'b1, 1'b0);
      send_item(REQ_FIND_OLDEST, 1'b1, 4'd0, 1'b1, 1'b0);
      repeat (4) send_item(REQ_SCHEDULE, 1'b0, 4'd0, 1'b1, 1'b0);
      send_item(REQ_REMOVE_CUR, 1'b0, 4'd0, 1'b1, 1'b0);
      send_item(REQ_REMOVE_ID, 1'b0, 4'd0, 1'b1, 1'b0);    // oldest of A, lowers the rest
      send_item(REQ_FIND_OLDEST, 1'b0, 4'd0, 1'b1, 1'b0);
      send_item(REQ_REMOVE_ID, 1'b1, 4'hF, 1'b0, 1'b0);    // free slot
      for (k = int'(REQ_FIND_OLDEST) + 1; k < 2**REQ_TYPE_W; k++)
         send_item(REQ_TYPE_W'(k), 1'b1, 4'hF, 1'b1, 1'b1);

      run_phase(0, 0, 16'd8000, 16'hFFFF, 1'b1);
      run_phase(53, 0, CSR_DATA_W'($urandom_range(8000)), CSR_DATA_W'($urandom_range(65535)),
                1'b0);
      run_phase(0, 53, 16'd0, 16'd0, 1'b0);
      run_phase(15, 15, CSR_DATA_W'($urandom_range(8000)), CSR_DATA_W'($urandom_range(65535)),
                1'b0);
      wait_drained();

      if (sb.errors == 0 && sb.pending() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: sim.f
rtl/tgts_pkg.sv
rtl/tgts_slot_table.sv
rtl/tgts_sequencer.sv
rtl/two_group_task_slot_scheduler_unit.sv
sim/tb_two_group_task_slot_scheduler_unit.sv
